// ----- rtl/hsv2rgb_pkg.sv -----
// Package for the HSV to RGB converter: widths, arithmetic constants,
// sector codes, register indexes and the configuration struct.
// Has no dependencies; used by hsv2rgb_pipe and hsv_to_rgb_converter.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Field widths
  localparam int unsigned HueW  = 16;
  localparam int unsigned PctW  = 7;
  localparam int unsigned ChanW = 8;
  localparam int unsigned CfgIdxW = 1;

  // Arithmetic constants
  localparam int unsigned HueTurn   = 360;
  localparam int unsigned SectorDeg = 60;
  localparam int unsigned PctFull   = 100;
  localparam int unsigned ChanFull  = 255;

  // Reciprocals for exact truncating division by constants over the
  // value ranges that reach them (hue < 2^16, percent products <= 25500,
  // sector products <= 15045)
  localparam int unsigned TurnRecip    = 93207;  // ceil(2^25 / 360)
  localparam int unsigned TurnShift    = 25;
  localparam int unsigned PctRecip     = 5243;   // ceil(2^19 / 100)
  localparam int unsigned PctShift     = 19;
  localparam int unsigned SectorRecip  = 34953;  // ceil(2^21 / 60)
  localparam int unsigned SectorShift  = 21;

  // Cycles from an accepted start to the result strobe
  localparam int unsigned Latency = 7;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegSat = 1'b0;
  localparam logic [CfgIdxW-1:0] RegVal = 1'b1;

  // Six hue sectors, each named by the colours where it starts and where it ends
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // Saturation and value as held in the configuration registers
  typedef struct packed {
    logic [PctW-1:0] sat;
    logic [PctW-1:0] val;
  } cfg_t;

  // Limit a percentage to full scale
  function automatic logic [PctW-1:0] clamp_pct(input logic [PctW-1:0] p);
    logic [PctW-1:0] r;
    r = (p > PctW'(PctFull)) ? PctW'(PctFull) : p;
    return r;
  endfunction

endpackage

// ----- rtl/hsv2rgb_pipe.sv -----
// Seven-stage arithmetic pipeline of the HSV to RGB converter.
// Depends on hsv2rgb_pkg for widths, reciprocals, sector codes and cfg_t.
`timescale 1ns / 1ps

module hsv2rgb_pipe (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic [hsv2rgb_pkg::HueW-1:0]        hue_i,
  input  hsv2rgb_pkg::cfg_t                   cfg_i,
  output logic                                out_valid_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]       red_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]       green_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]       blue_o
);

  localparam int unsigned CW = hsv2rgb_pkg::ChanW;
  localparam int unsigned PW = hsv2rgb_pkg::PctW;
  localparam int unsigned HW = hsv2rgb_pkg::HueW;

  // Valid bits, one per stage
  logic [hsv2rgb_pkg::Latency-1:0] vld_d, vld_q;

  // Stage 1: quotient of hue by a full turn, value times full channel
  logic [HW-1:0]      hue1_q;
  logic [7:0]         quo1_d, quo1_q;
  logic [14:0]        v255_1_d, v255_1_q;
  logic [PW-1:0]      sat1_d, sat1_q;
  logic [32:0]        quo_prod;
  logic [PW-1:0]      val_c;

  // Stage 2: reduced hue, top level
  logic [8:0]         hmod2_d, hmod2_q;
  logic [CW-1:0]      hi2_d, hi2_q;
  logic [PW-1:0]      sat2_q;
  logic [16:0]        turn_sub;
  logic [27:0]        hi_prod;

  // Stage 3: sector split, bottom level product
  hsv2rgb_pkg::sector_e sec3_d, sec3_q;
  logic [5:0]         rem3_d, rem3_q;
  logic [14:0]        lop3_d, lop3_q;
  logic [CW-1:0]      hi3_q;
  logic [8:0]         sec_base;

  // Stage 4: bottom level
  logic [CW-1:0]      lo4_d, lo4_q, hi4_q;
  hsv2rgb_pkg::sector_e sec4_q;
  logic [5:0]         rem4_q;
  logic [27:0]        lo_prod;

  // Stage 5: span times remainder
  logic [13:0]        adjp5_d, adjp5_q;
  logic [CW-1:0]      hi5_q, lo5_q;
  hsv2rgb_pkg::sector_e sec5_q;

  // Stage 6: ramp term
  logic [CW-1:0]      adj6_d, adj6_q, hi6_q, lo6_q;
  hsv2rgb_pkg::sector_e sec6_q;
  logic [29:0]        adj_prod;

  // Stage 7: output registers
  logic [CW-1:0]      red_d, red_q, green_d, green_q, blue_d, blue_q;
  logic [CW-1:0]      rise, fall;

  // Advance valid bits
  assign vld_d = {vld_q[hsv2rgb_pkg::Latency-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1 logic
  always_comb begin
    quo_prod = 33'(hue_i) * 33'(hsv2rgb_pkg::TurnRecip);
    quo1_d   = quo_prod[hsv2rgb_pkg::TurnShift +: 8];
    val_c    = hsv2rgb_pkg::clamp_pct(cfg_i.val);
    v255_1_d = {val_c, 8'd0} - 15'(val_c);
    sat1_d   = hsv2rgb_pkg::clamp_pct(cfg_i.sat);
  end

  // Stage 2 logic
  always_comb begin
    turn_sub = 17'(hue1_q) - 17'(quo1_q) * 17'(hsv2rgb_pkg::HueTurn);
    hmod2_d  = turn_sub[8:0];
    hi_prod  = 28'(v255_1_q) * 28'(hsv2rgb_pkg::PctRecip);
    hi2_d    = hi_prod[hsv2rgb_pkg::PctShift +: CW];
  end

  // Stage 3 logic: pick the sector by comparing against its edges
  always_comb begin
    if (hmod2_q >= 9'(5 * hsv2rgb_pkg::SectorDeg)) begin
      sec3_d   = hsv2rgb_pkg::SEC_MAG_RED;
      sec_base = 9'(5 * hsv2rgb_pkg::SectorDeg);
    end else if (hmod2_q >= 9'(4 * hsv2rgb_pkg::SectorDeg)) begin
      sec3_d   = hsv2rgb_pkg::SEC_BLU_MAG;
      sec_base = 9'(4 * hsv2rgb_pkg::SectorDeg);
    end else if (hmod2_q >= 9'(3 * hsv2rgb_pkg::SectorDeg)) begin
      sec3_d   = hsv2rgb_pkg::SEC_CYN_BLU;
      sec_base = 9'(3 * hsv2rgb_pkg::SectorDeg);
    end else if (hmod2_q >= 9'(2 * hsv2rgb_pkg::SectorDeg)) begin
      sec3_d   = hsv2rgb_pkg::SEC_GRN_CYN;
      sec_base = 9'(2 * hsv2rgb_pkg::SectorDeg);
    end else if (hmod2_q >= 9'(hsv2rgb_pkg::SectorDeg)) begin
      sec3_d   = hsv2rgb_pkg::SEC_YEL_GRN;
      sec_base = 9'(hsv2rgb_pkg::SectorDeg);
    end else begin
      sec3_d   = hsv2rgb_pkg::SEC_RED_YEL;
      sec_base = 9'd0;
    end
    rem3_d = 6'(hmod2_q - sec_base);
    lop3_d = 15'(hi2_q) * (15'(hsv2rgb_pkg::PctFull) - 15'(sat2_q));
  end

  // Stage 4 logic
  always_comb begin
    lo_prod = 28'(lop3_q) * 28'(hsv2rgb_pkg::PctRecip);
    lo4_d   = lo_prod[hsv2rgb_pkg::PctShift +: CW];
  end

  // Stage 5 logic
  assign adjp5_d = 14'(hi4_q - lo4_q) * 14'(rem4_q);

  // Stage 6 logic
  always_comb begin
    adj_prod = 30'(adjp5_q) * 30'(hsv2rgb_pkg::SectorRecip);
    adj6_d   = adj_prod[hsv2rgb_pkg::SectorShift +: CW];
  end

  // Stage 7 logic: place top, bottom and ramps by sector
  always_comb begin
    rise = lo6_q + adj6_q;
    fall = hi6_q - adj6_q;
    case (sec6_q)
      hsv2rgb_pkg::SEC_RED_YEL: begin
        red_d = hi6_q; green_d = rise;  blue_d = lo6_q;
      end
      hsv2rgb_pkg::SEC_YEL_GRN: begin
        red_d = fall;  green_d = hi6_q; blue_d = lo6_q;
      end
      hsv2rgb_pkg::SEC_GRN_CYN: begin
        red_d = lo6_q; green_d = hi6_q; blue_d = rise;
      end
      hsv2rgb_pkg::SEC_CYN_BLU: begin
        red_d = lo6_q; green_d = fall;  blue_d = hi6_q;
      end
      hsv2rgb_pkg::SEC_BLU_MAG: begin
        red_d = rise;  green_d = lo6_q; blue_d = hi6_q;
      end
      default: begin
        red_d = hi6_q; green_d = lo6_q; blue_d = fall;
      end
    endcase
  end

  // Data registers; every stage loads each cycle, valid bits say what counts
  always_ff @(posedge clk_i) begin
    hue1_q   <= hue_i;
    quo1_q   <= quo1_d;
    v255_1_q <= v255_1_d;
    sat1_q   <= sat1_d;

    hmod2_q  <= hmod2_d;
    hi2_q    <= hi2_d;
    sat2_q   <= sat1_q;

    sec3_q   <= sec3_d;
    rem3_q   <= rem3_d;
    lop3_q   <= lop3_d;
    hi3_q    <= hi2_q;

    lo4_q    <= lo4_d;
    hi4_q    <= hi3_q;
    sec4_q   <= sec3_q;
    rem4_q   <= rem3_q;

    adjp5_q  <= adjp5_d;
    hi5_q    <= hi4_q;
    lo5_q    <= lo4_q;
    sec5_q   <= sec4_q;

    adj6_q   <= adj6_d;
    hi6_q    <= hi5_q;
    lo6_q    <= lo5_q;
    sec6_q   <= sec5_q;

    red_q    <= red_d;
    green_q  <= green_d;
    blue_q   <= blue_d;
  end

  assign out_valid_o = vld_q[hsv2rgb_pkg::Latency-1];
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  // Every item entering leaves the pipeline with a result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> ##7 out_valid_o)
    else $error("hsv2rgb_pipe: result strobe missing after latency");

  // Hue reduction stays inside one turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (hmod2_q < 9'(hsv2rgb_pkg::HueTurn)))
    else $error("hsv2rgb_pipe: reduced hue out of range");

  // Sector remainder stays inside one sector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (rem3_q < 6'(hsv2rgb_pkg::SectorDeg)))
    else $error("hsv2rgb_pipe: sector remainder out of range");

  // Bottom level never rises above top level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (lo4_q <= hi4_q))
    else $error("hsv2rgb_pipe: bottom level above top level");

  // Ramp term never exceeds the span it scales
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> (adj6_q <= (hi6_q - lo6_q)))
    else $error("hsv2rgb_pipe: ramp term exceeds span");

endmodule

// ----- rtl/hsv_to_rgb_converter.sv -----
// Top level of the HSV to RGB converter: configuration registers and the
// command interface around the arithmetic pipeline.
// Depends on hsv2rgb_pkg and hsv2rgb_pipe.
//
//   Channel   Signals                           Direction  Beat taken when
//   -------   -------------------------------   ---------  --------------------
//   command   start_i, busy_o, hue_i            in         start_i && !busy_o
//   result    valid_o, red_o, green_o, blue_o   out        valid_o (one cycle)
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i  in         cfg_we_i
//
// One hue enters per cycle; its result strobes after the seven register stages of
// the pipeline (hue reduction, four reciprocal multiplies, two level products, a
// sector compare chain and the output multiplexer).
// busy_o stays low: every command beat is taken.
// Reset clears the valid bits and sets saturation and value to 100.
// The receiver cannot stall, so no stage ever holds.
`timescale 1ns / 1ps

module hsv_to_rgb_converter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [hsv2rgb_pkg::HueW-1:0]         hue_i,
  output logic                                 valid_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]        red_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]        green_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]        blue_o,
  input  logic                                 cfg_we_i,
  input  logic [hsv2rgb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [hsv2rgb_pkg::PctW-1:0]         cfg_wdata_i
);

  hsv2rgb_pkg::cfg_t cfg_d, cfg_q;
  logic              accept;

  // Take a command beat whenever start is raised
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        hsv2rgb_pkg::RegSat: cfg_d.sat = cfg_wdata_i;
        hsv2rgb_pkg::RegVal: cfg_d.val = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sat <= hsv2rgb_pkg::PctW'(hsv2rgb_pkg::PctFull);
      cfg_q.val <= hsv2rgb_pkg::PctW'(hsv2rgb_pkg::PctFull);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Arithmetic pipeline
  hsv2rgb_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .hue_i       (hue_i),
    .cfg_i       (cfg_q),
    .out_valid_o (valid_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

endmodule

// ----- tb/tb_hsv_to_rgb_converter.sv -----
// Self-checking testbench for hsv_to_rgb_converter: directed hue table, then
// random hue beats over a series of saturation and value settings.
// Depends on hsv2rgb_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;

  localparam int unsigned HW = hsv2rgb_pkg::HueW;
  localparam int unsigned PW = hsv2rgb_pkg::PctW;
  localparam int unsigned CW = hsv2rgb_pkg::ChanW;

  localparam int unsigned StallLimit    = 400;
  localparam int unsigned NumPhases     = 11;
  localparam int unsigned BeatsPerPhase = 150;
  localparam int unsigned MaxReports    = 50;

  typedef struct packed {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
  } pixel_t;

  // One directed row: settings, hue, and a hand-read colour where obvious
  typedef struct packed {
    logic [PW-1:0]  sat;
    logic [PW-1:0]  val;
    logic [HW-1:0]  hue;
    logic           known;
    pixel_t         pix;
  } hue_row_t;

  localparam int unsigned NumRows = 22;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [HW-1:0]    hue_i;
  logic             valid_o;
  logic [CW-1:0]    red_o;
  logic [CW-1:0]    green_o;
  logic [CW-1:0]    blue_o;
  logic             cfg_we_i;
  logic [hsv2rgb_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [PW-1:0]    cfg_wdata_i;

  // Settings as the block holds them, and the colours still owed by it
  logic [PW-1:0]   sat_cfg;
  logic [PW-1:0]   val_cfg;
  pixel_t          colour_q[$];
  logic            hand_valid;
  pixel_t          hand_pixel;
  int unsigned     err_cnt;
  int unsigned     stall_cnt;

  hue_row_t hue_rows [NumRows] = '{
    '{7'd100, 7'd100, 16'd0,     1'b1, '{8'd255, 8'd0,   8'd0}},
    '{7'd100, 7'd100, 16'd60,    1'b1, '{8'd255, 8'd255, 8'd0}},
    '{7'd100, 7'd100, 16'd120,   1'b1, '{8'd0,   8'd255, 8'd0}},
    '{7'd100, 7'd100, 16'd180,   1'b1, '{8'd0,   8'd255, 8'd255}},
    '{7'd100, 7'd100, 16'd240,   1'b1, '{8'd0,   8'd0,   8'd255}},
    '{7'd100, 7'd100, 16'd300,   1'b1, '{8'd255, 8'd0,   8'd255}},
    '{7'd100, 7'd100, 16'd360,   1'b1, '{8'd255, 8'd0,   8'd0}},
    '{7'd100, 7'd100, 16'd30,    1'b0, '0},
    '{7'd100, 7'd100, 16'd90,    1'b0, '0},
    '{7'd100, 7'd100, 16'd150,   1'b0, '0},
    '{7'd100, 7'd100, 16'd210,   1'b0, '0},
    '{7'd100, 7'd100, 16'd270,   1'b0, '0},
    '{7'd100, 7'd100, 16'd330,   1'b0, '0},
    '{7'd100, 7'd100, 16'd359,   1'b0, '0},
    '{7'd100, 7'd100, 16'd65535, 1'b0, '0},
    '{7'd0,   7'd100, 16'd0,     1'b1, '{8'd255, 8'd255, 8'd255}},
    '{7'd100, 7'd0,   16'd200,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{7'd127, 7'd127, 16'd0,     1'b1, '{8'd255, 8'd0,   8'd0}},
    '{7'd127, 7'd127, 16'd100,   1'b0, '0},
    '{7'd101, 7'd50,  16'd45,    1'b0, '0},
    '{7'd0,   7'd127, 16'd65535, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{7'd50,  7'd0,   16'd0,     1'b1, '{8'd0,   8'd0,   8'd0}}
  };

  hsv_to_rgb_converter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .hue_i       (hue_i),
    .valid_o     (valid_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Colour of one hue under the given settings, percentages limited to full scale
  function automatic pixel_t hsv_pixel(input logic [HW-1:0] hue,
                                       input logic [PW-1:0] sat_raw,
                                       input logic [PW-1:0] val_raw);
    int unsigned h;
    int unsigned s;
    int unsigned v;
    int unsigned top;
    int unsigned bot;
    int unsigned rem;
    int unsigned ramp;
    hsv2rgb_pkg::sector_e sec;
    pixel_t      px;
    h    = hue % hsv2rgb_pkg::HueTurn;
    s    = (sat_raw > hsv2rgb_pkg::PctFull) ? hsv2rgb_pkg::PctFull : sat_raw;
    v    = (val_raw > hsv2rgb_pkg::PctFull) ? hsv2rgb_pkg::PctFull : val_raw;
    top  = v * hsv2rgb_pkg::ChanFull / hsv2rgb_pkg::PctFull;
    bot  = top * (hsv2rgb_pkg::PctFull - s) / hsv2rgb_pkg::PctFull;
    sec  = hsv2rgb_pkg::sector_e'(h / hsv2rgb_pkg::SectorDeg);
    rem  = h % hsv2rgb_pkg::SectorDeg;
    ramp = (top - bot) * rem / hsv2rgb_pkg::SectorDeg;
    case (sec)
      hsv2rgb_pkg::SEC_RED_YEL: begin
        px.red = CW'(top);        px.green = CW'(bot + ramp); px.blue = CW'(bot);
      end
      hsv2rgb_pkg::SEC_YEL_GRN: begin
        px.red = CW'(top - ramp); px.green = CW'(top);        px.blue = CW'(bot);
      end
      hsv2rgb_pkg::SEC_GRN_CYN: begin
        px.red = CW'(bot);        px.green = CW'(top);        px.blue = CW'(bot + ramp);
      end
      hsv2rgb_pkg::SEC_CYN_BLU: begin
        px.red = CW'(bot);        px.green = CW'(top - ramp); px.blue = CW'(top);
      end
      hsv2rgb_pkg::SEC_BLU_MAG: begin
        px.red = CW'(bot + ramp); px.green = CW'(bot);        px.blue = CW'(top);
      end
      default: begin
        px.red = CW'(top);        px.green = CW'(bot);        px.blue = CW'(top - ramp);
      end
    endcase
    return px;
  endfunction

  task automatic check_chan(input string chan, input logic [CW-1:0] want,
                            input logic [CW-1:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= MaxReports)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, chan, want, got);
    end
  endtask

  // Check each result beat against the oldest colour owed, then log new hue beats
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni) begin
      if (valid_o) begin
        if (colour_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t: result with none expected, expected none actual %0d/%0d/%0d",
                     $time, red_o, green_o, blue_o);
        end else begin
          want = colour_q.pop_front();
          check_chan("red", want.red, red_o);
          check_chan("green", want.green, green_o);
          check_chan("blue", want.blue, blue_o);
        end
      end
      if (start_i && !busy_o) begin
        if (hand_valid)
          colour_q.push_back(hand_pixel);
        else
          colour_q.push_back(hsv_pixel(hue_i, sat_cfg, val_cfg));
      end
    end
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || valid_o || (start_i && !busy_o) || cfg_we_i) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("%0t: no beat for %0d cycles", $time, StallLimit);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Offer one hue beat, maybe after a short idle burst, and hold until taken
  task automatic send_hue(input logic [HW-1:0] hue, input bit may_idle,
                          input bit known, input pixel_t pix);
    int unsigned gap;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk_i);
        start_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    start_i    <= 1'b1;
    hue_i      <= hue;
    hand_valid = known;
    hand_pixel = pix;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Lower start and wait until every owed colour has come back
  task automatic drain;
    @(negedge clk_i);
    start_i    <= 1'b0;
    hand_valid = 1'b0;
    while (colour_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_settings(input logic [PW-1:0] sat, input logic [PW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= hsv2rgb_pkg::RegSat;
    cfg_wdata_i <= sat;
    sat_cfg     = sat;
    @(negedge clk_i);
    cfg_idx_i   <= hsv2rgb_pkg::RegVal;
    cfg_wdata_i <= val;
    val_cfg     = val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [PW-1:0] random_pct();
    if ($urandom_range(0, 1) == 0)
      return PW'($urandom_range(0, 127));
    return PW'($urandom_range(0, hsv2rgb_pkg::PctFull));
  endfunction

  // Hue mix: full 16-bit range, one turn, and sector edges
  function automatic logic [HW-1:0] random_hue();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5)
      return HW'($urandom);
    if (pick < 8)
      return HW'($urandom_range(0, hsv2rgb_pkg::HueTurn - 1));
    return HW'(hsv2rgb_pkg::SectorDeg * $urandom_range(1, 1092) +
               $urandom_range(0, 2) - 1);
  endfunction

  initial begin
    logic [PW-1:0] sat;
    logic [PW-1:0] val;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    hue_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = hsv2rgb_pkg::RegSat;
    cfg_wdata_i = '0;
    sat_cfg     = PW'(hsv2rgb_pkg::PctFull);
    val_cfg     = PW'(hsv2rgb_pkg::PctFull);
    hand_valid  = 1'b0;
    hand_pixel  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: change settings only once the pipeline is empty
    foreach (hue_rows[i]) begin
      if (hue_rows[i].sat != sat_cfg || hue_rows[i].val != val_cfg) begin
        drain();
        write_settings(hue_rows[i].sat, hue_rows[i].val);
      end
      send_hue(hue_rows[i].hue, 1'b1, hue_rows[i].known, hue_rows[i].pix);
    end

    // Random phases, extremes of the settings first; no idling in the last one
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       begin sat = 7'd100; val = 7'd100; end
        1:       begin sat = 7'd0;   val = 7'd0;   end
        2:       begin sat = 7'd127; val = 7'd127; end
        3:       begin sat = 7'd0;   val = 7'd127; end
        4:       begin sat = 7'd127; val = 7'd0;   end
        5:       begin sat = 7'd100; val = 7'd1;   end
        default: begin sat = random_pct(); val = random_pct(); end
      endcase
      drain();
      write_settings(sat, val);
      for (int n = 0; n < BeatsPerPhase; n++)
        send_hue(random_hue(), p != NumPhases - 1, 1'b0, '0);
    end

    drain();
    repeat (hsv2rgb_pkg::Latency + 2) @(negedge clk_i);
    if (colour_q.size() != 0) begin
      $display("%0t: colours still owed, expected 0 actual %0d", $time, colour_q.size());
    end
    if (err_cnt == 0 && colour_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_pipe.sv
rtl/hsv_to_rgb_converter.sv
tb/tb_hsv_to_rgb_converter.sv
